FILE: rtl/core/pcis_pkg.sv
// Shared constants, types and saturation helpers of the contact impulse solver.
`timescale 1ns / 1ps
package pcis_pkg;

  // Particle count; a power of two, so that index reduction is a truncation.
  localparam int MAX_PARTICLES = 1024;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int IN_IDX_W      = 10;
  localparam int POS_W         = 96;
  localparam int VM_W          = 127;
  localparam int DIV_NW        = 48;
  localparam int DIV_DW        = 32;
  localparam int DIV_CW        = $clog2(DIV_NW);

  localparam logic [2:0] ACT_LOAD_POS = 3'd0;
  localparam logic [2:0] ACT_LOAD_VEL = 3'd1;
  localparam logic [2:0] ACT_CONTACT  = 3'd2;
  localparam logic [2:0] ACT_INTEG    = 3'd3;
  localparam logic [2:0] ACT_READ_POS = 3'd4;
  localparam logic [2:0] ACT_READ_VEL = 3'd5;

  localparam logic [1:0] CFG_TIME_STEP  = 2'd0;
  localparam logic [1:0] CFG_STEP_RECIP = 2'd1;
  localparam logic [1:0] CFG_GRAVITY_Y  = 2'd2;

  localparam logic [30:0] TIME_STEP_RST  = 31'd1092;
  localparam logic [30:0] STEP_RECIP_RST = 31'd3932160;
  localparam logic signed [31:0] GRAVITY_RST = -32'sd642908;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ISSUE = 9'b000000010,
    S_WAITA = 9'b000000100,
    S_WAITB = 9'b000001000,
    S_MUL   = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_APPLY = 9'b001000000,
    S_INT   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  function automatic logic signed [63:0] sx64(input logic signed [31:0] x);
    return $signed({{32{x[31]}}, x});
  endfunction

  function automatic sat_t sat32(input logic signed [63:0] x);
    sat_t r;
    if (x > S32_MAX) begin
      r.val  = 32'sh7FFFFFFF;
      r.clip = 1'b1;
    end else if (x < S32_MIN) begin
      r.val  = 32'sh80000000;
      r.clip = 1'b1;
    end else begin
      r.val  = x[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick(input logic [IN_IDX_W-1:0] i);
    logic [IDX_W+IN_IDX_W-1:0] t;
    t = {{IDX_W{1'b0}}, i};
    return t[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/core/pcis_ram.sv
// Generic single-port-write, registered-read synchronous RAM.
`timescale 1ns / 1ps
module pcis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pcis_div.sv
// Restoring unsigned divider producing one quotient bit per cycle.
`timescale 1ns / 1ps
module pcis_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pcis_pkg::DIV_NW-1:0]   num,
  input  logic [pcis_pkg::DIV_DW-1:0]   den,
  output pcis_pkg::div_stat_t           stat,
  output logic [pcis_pkg::DIV_NW-1:0]   quot
);
  import pcis_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW:0]   sh;
  logic [DIV_DW+1:0] diff;
  logic              ge;
  logic [DIV_DW-1:0] rem_nxt;

  always_comb begin
    sh      = {rem_r, quo_r[DIV_NW-1]};
    diff    = {1'b0, sh} - {2'b00, den_r};
    ge      = ~diff[DIV_DW+1];
    rem_nxt = ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == DIV_CW'(DIV_NW - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;

endmodule

FILE: rtl/core/particle_contact_impulse_solver_core.sv
// Loads and unused codes pass from issue to done, reads also wait on the memory read,
// integrate adds the integration steps and a contact the multiply, divide and apply steps
// (multiply only when both inverse masses are zero); an output stall holds the item in done.
// A contact is bounded by the 48-step divider; all products share one multiplier.
// One item is in work at a time; the next is taken once the result is staged.
// Reset clears control state and restores the register defaults; the particle
// memories are undefined until loaded and are not cleared.
`timescale 1ns / 1ps
module particle_contact_impulse_solver_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_action,
  input  logic [pcis_pkg::IN_IDX_W-1:0]  in_index_a,
  input  logic [pcis_pkg::IN_IDX_W-1:0]  in_index_b,
  input  logic signed [31:0]             in_vec_x,
  input  logic signed [31:0]             in_vec_y,
  input  logic signed [31:0]             in_vec_z,
  input  logic signed [31:0]             in_scalar_in,
  input  logic [30:0]                    in_impulse_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [30:0]                    out_impulse_out,
  output logic signed [31:0]             out_res_x,
  output logic signed [31:0]             out_res_y,
  output logic signed [31:0]             out_res_z,
  output logic [30:0]                    out_res_inv_mass,
  output logic                           out_degenerate,
  output logic                           out_saturated
);
  import pcis_pkg::*;

  state_t state_r, state_nxt;
  logic [2:0] step_r;
  logic       ph_r;

  logic [30:0]        dt_r, rcp_r;
  logic signed [31:0] gy_r;

  logic [2:0]         act_r;
  logic [IDX_W-1:0]   ia_r, ib_r;
  logic signed [31:0] n_r [3];
  logic signed [31:0] gap_r;
  logic [30:0]        impin_r;

  logic signed [31:0] va_r [3];
  logic signed [31:0] vb_r [3];
  logic signed [31:0] pa_r [3];
  logic signed [31:0] d_r  [3];
  logic [30:0]        ima_r, imb_r;
  logic signed [63:0] rel_r;
  logic               rneg_r;
  logic signed [31:0] change_r;
  logic signed [31:0] w_r;
  logic signed [63:0] prod_r;

  logic [30:0]        st_imp_r, st_im_r;
  logic signed [31:0] st_x_r, st_y_r, st_z_r;
  logic               st_deg_r, st_sat_r;

  logic               out_valid_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [1:0]         ax_mul, ax_app, ax_int;

  logic               pos_we, vm_we;
  logic [IDX_W-1:0]   raddr, vm_waddr;
  logic [POS_W-1:0]   pos_wdata, pos_rdata;
  logic [VM_W-1:0]    vm_wdata, vm_rdata;
  logic [30:0]        im_load;

  sat_t               rm;
  logic [32:0]        rm_abs;
  logic [31:0]        im_sum;
  logic               div_start;
  div_stat_t          div_stat;
  logic [DIV_NW-1:0]  div_q;
  logic signed [49:0] imp_s, nw_s;
  logic [30:0]        nw31;
  logic               nw_clip;

  logic in_acc;
  logic out_free;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign ax_mul = step_r[1:0];
  assign ax_app = step_r[1:0] + 2'd2;
  assign ax_int = step_r[1:0] - 2'd1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL: begin
        if (step_r == 3'd3) begin
          mul_a = {gap_r[31], gap_r};
          mul_b = {2'b00, rcp_r};
        end else if (step_r < 3'd3) begin
          mul_a = {d_r[ax_mul][31], d_r[ax_mul]};
          mul_b = {n_r[ax_mul][31], n_r[ax_mul]};
        end
      end
      S_APPLY: begin
        if (step_r == 3'd0) begin
          mul_a = {change_r[31], change_r};
          mul_b = {2'b00, (ph_r ? imb_r : ima_r)};
        end else if (step_r >= 3'd2 && step_r <= 3'd4) begin
          mul_a = {w_r[31], w_r};
          mul_b = {n_r[ax_app][31], n_r[ax_app]};
        end
      end
      S_INT: begin
        if (step_r == 3'd3) begin
          mul_a = {gy_r[31], gy_r};
          mul_b = {2'b00, dt_r};
        end else if (step_r < 3'd3) begin
          mul_a = {va_r[ax_mul][31], va_r[ax_mul]};
          mul_b = {2'b00, dt_r};
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    rm        = sat32(rel_r - (prod_r >>> 16));
    rm_abs    = rm.val[31] ? -{rm.val[31], rm.val} : {1'b0, rm.val};
    im_sum    = {1'b0, ima_r} + {1'b0, imb_r};
    div_start = (state_r == S_MUL) && (step_r == 3'd4) && (im_sum != '0);
    imp_s     = rneg_r ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
    nw_s      = imp_s + $signed({19'd0, impin_r});
    nw_clip   = 1'b0;
    if (nw_s < 0) begin
      nw31 = '0;
    end else if (nw_s > 50'sh7FFFFFFF) begin
      nw31    = 31'h7FFFFFFF;
      nw_clip = 1'b1;
    end else begin
      nw31 = nw_s[30:0];
    end
    im_load = gap_r[31] ? 31'd0 : gap_r[30:0];
  end

  always_comb begin
    raddr     = (state_r == S_WAITA) ? ib_r : ia_r;
    pos_we    = ((state_r == S_ISSUE) && (act_r == ACT_LOAD_POS)) ||
                ((state_r == S_INT) && (step_r == 3'd5));
    pos_wdata = (state_r == S_ISSUE) ? {n_r[2], n_r[1], n_r[0]} : {pa_r[2], pa_r[1], pa_r[0]};
    vm_we     = ((state_r == S_ISSUE) && (act_r == ACT_LOAD_VEL)) ||
                ((state_r == S_INT) && (step_r == 3'd5)) ||
                ((state_r == S_APPLY) && (step_r == 3'd6));
    vm_waddr  = ((state_r == S_APPLY) && ph_r) ? ib_r : ia_r;
    if (state_r == S_ISSUE) begin
      vm_wdata = {im_load, n_r[2], n_r[1], n_r[0]};
    end else if ((state_r == S_APPLY) && ph_r) begin
      vm_wdata = {imb_r, vb_r[2], vb_r[1], vb_r[0]};
    end else begin
      vm_wdata = {ima_r, va_r[2], va_r[1], va_r[0]};
    end
  end

  pcis_ram #(.WIDTH(POS_W), .DEPTH(MAX_PARTICLES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (ia_r),
    .wdata (pos_wdata),
    .raddr (raddr),
    .rdata (pos_rdata)
  );

  pcis_ram #(.WIDTH(VM_W), .DEPTH(MAX_PARTICLES)) u_vm_ram (
    .clk   (clk),
    .we    (vm_we),
    .waddr (vm_waddr),
    .wdata (vm_wdata),
    .raddr (raddr),
    .rdata (vm_rdata)
  );

  pcis_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({rm_abs[31:0], 16'd0}),
    .den   (im_sum),
    .stat  (div_stat),
    .quot  (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (act_r == ACT_CONTACT || act_r == ACT_INTEG ||
            act_r == ACT_READ_POS || act_r == ACT_READ_VEL) begin
          state_nxt = S_WAITA;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WAITA: begin
        if (act_r == ACT_CONTACT) begin
          state_nxt = S_WAITB;
        end else if (act_r == ACT_INTEG) begin
          state_nxt = S_INT;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WAITB: state_nxt = S_MUL;
      S_MUL: begin
        if (step_r == 3'd4) begin
          state_nxt = (im_sum == '0) ? S_DONE : S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (step_r == 3'd6 && ph_r) begin
          state_nxt = S_DONE;
        end
      end
      S_INT: begin
        if (step_r == 3'd5) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      dt_r        <= TIME_STEP_RST;
      rcp_r       <= STEP_RECIP_RST;
      gy_r        <= GRAVITY_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TIME_STEP:  dt_r  <= cfg_wdata[30:0];
          CFG_STEP_RECIP: rcp_r <= cfg_wdata[30:0];
          CFG_GRAVITY_Y:  gy_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sat_t s0, s1, s2;
    prod_r <= $signed(mul_p[63:0]);
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_r    <= in_action;
          ia_r     <= pick(in_index_a);
          ib_r     <= pick(in_index_b);
          n_r[0]   <= in_vec_x;
          n_r[1]   <= in_vec_y;
          n_r[2]   <= in_vec_z;
          gap_r    <= in_scalar_in;
          impin_r  <= in_impulse_in;
          st_imp_r <= '0;
          st_im_r  <= '0;
          st_x_r   <= '0;
          st_y_r   <= '0;
          st_z_r   <= '0;
          st_deg_r <= 1'b0;
          st_sat_r <= 1'b0;
        end
      end
      S_ISSUE: begin
        if (act_r == ACT_LOAD_VEL && gap_r[31]) begin
          st_sat_r <= 1'b1;
        end
      end
      S_WAITA: begin
        va_r[0] <= vm_rdata[31:0];
        va_r[1] <= vm_rdata[63:32];
        va_r[2] <= vm_rdata[95:64];
        ima_r   <= vm_rdata[126:96];
        pa_r[0] <= pos_rdata[31:0];
        pa_r[1] <= pos_rdata[63:32];
        pa_r[2] <= pos_rdata[95:64];
        step_r  <= '0;
        if (act_r == ACT_READ_POS) begin
          st_x_r <= pos_rdata[31:0];
          st_y_r <= pos_rdata[63:32];
          st_z_r <= pos_rdata[95:64];
        end else if (act_r == ACT_READ_VEL) begin
          st_x_r  <= vm_rdata[31:0];
          st_y_r  <= vm_rdata[63:32];
          st_z_r  <= vm_rdata[95:64];
          st_im_r <= vm_rdata[126:96];
        end
      end
      S_WAITB: begin
        s0 = sat32(sx64(vm_rdata[31:0]) - sx64(va_r[0]));
        s1 = sat32(sx64(vm_rdata[63:32]) - sx64(va_r[1]));
        s2 = sat32(sx64(vm_rdata[95:64]) - sx64(va_r[2]));
        vb_r[0] <= vm_rdata[31:0];
        vb_r[1] <= vm_rdata[63:32];
        vb_r[2] <= vm_rdata[95:64];
        imb_r   <= vm_rdata[126:96];
        d_r[0]  <= s0.val;
        d_r[1]  <= s1.val;
        d_r[2]  <= s2.val;
        if (s0.clip || s1.clip || s2.clip) begin
          st_sat_r <= 1'b1;
        end
        step_r <= '0;
      end
      S_MUL: begin
        step_r <= step_r + 3'd1;
        if (step_r == 3'd1) begin
          rel_r <= prod_r >>> 14;
        end else if (step_r == 3'd2 || step_r == 3'd3) begin
          rel_r <= rel_r + (prod_r >>> 14);
        end else if (step_r == 3'd4) begin
          rneg_r <= rm.val[31];
          if (rm.clip) begin
            st_sat_r <= 1'b1;
          end
          if (im_sum == '0) begin
            st_deg_r <= 1'b1;
            st_imp_r <= impin_r;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          st_imp_r <= nw31;
          change_r <= $signed({1'b0, nw31}) - $signed({1'b0, impin_r});
          if (nw_clip) begin
            st_sat_r <= 1'b1;
          end
          step_r <= '0;
          ph_r   <= 1'b0;
        end
      end
      S_APPLY: begin
        step_r <= (step_r == 3'd6) ? 3'd0 : step_r + 3'd1;
        if (step_r == 3'd1) begin
          s0 = sat32(prod_r >>> 16);
          w_r <= s0.val;
          if (s0.clip) begin
            st_sat_r <= 1'b1;
          end
        end else if (step_r >= 3'd3 && step_r <= 3'd5) begin
          if (ph_r) begin
            s0 = sat32(sx64(vb_r[ax_app - 2'd1]) - (prod_r >>> 14));
            vb_r[ax_app - 2'd1] <= s0.val;
          end else begin
            s0 = sat32(sx64(va_r[ax_app - 2'd1]) + (prod_r >>> 14));
            va_r[ax_app - 2'd1] <= s0.val;
          end
          if (s0.clip) begin
            st_sat_r <= 1'b1;
          end
        end else if (step_r == 3'd6) begin
          ph_r <= 1'b1;
          if (!ph_r && ia_r == ib_r) begin
            vb_r[0] <= va_r[0];
            vb_r[1] <= va_r[1];
            vb_r[2] <= va_r[2];
          end
        end
      end
      S_INT: begin
        step_r <= step_r + 3'd1;
        if (step_r >= 3'd1 && step_r <= 3'd3) begin
          s0 = sat32(sx64(pa_r[ax_int]) + (prod_r >>> 16));
          pa_r[ax_int] <= s0.val;
          if (s0.clip) begin
            st_sat_r <= 1'b1;
          end
        end else if (step_r == 3'd4 && ima_r != '0) begin
          s0 = sat32(sx64(va_r[1]) + (prod_r >>> 16));
          va_r[1] <= s0.val;
          if (s0.clip) begin
            st_sat_r <= 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_impulse_out  <= st_imp_r;
          out_res_x        <= st_x_r;
          out_res_y        <= st_y_r;
          out_res_z        <= st_z_r;
          out_res_inv_mass <= st_im_r;
          out_degenerate   <= st_deg_r;
          out_saturated    <= st_sat_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_word_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output word raised without a finished item");
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!vm_we && !pos_we))
    else $error("memory written while idle");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking testbench of the particle contact impulse solver core.
`timescale 1ns / 1ps
module testbench;
  import pcis_pkg::*;

  localparam logic [2:0] ACT_SPARE_LO = 3'd6;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [2:0]         act;
    logic [9:0]         ia;
    logic [9:0]         ib;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] sc;
    logic [30:0]        imp;
  } word_t;

  typedef struct {
    logic [30:0]        imp;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [30:0]        im;
    logic               degen;
    logic               sat;
  } result_t;

  class solver_scoreboard;
    longint pos[1024][3];
    longint vel[1024][3];
    longint imass[1024];
    longint dt;
    longint recip;
    longint grav;
    bit clipped;
    int errors;
    result_t due[$];

    function new();
      dt = TIME_STEP_RST;
      recip = STEP_RECIP_RST;
      grav = GRAVITY_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        CFG_TIME_STEP: dt = longint'(v[30:0]);
        CFG_STEP_RECIP: recip = longint'(v[30:0]);
        CFG_GRAVITY_Y: grav = longint'($signed(v));
        default: ;
      endcase
    endfunction

    function longint clip32(longint x);
      if (x > 64'sd2147483647) begin
        clipped = 1;
        return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
        clipped = 1;
        return -64'sd2147483648;
      end
      return x;
    endfunction

    function void push_impulse(int p, longint change, longint n[3], bit negate);
      longint w, d;
      w = clip32((change * imass[p]) >>> 16);
      for (int ax = 0; ax < 3; ax++) begin
        d = (w * n[ax]) >>> 14;
        vel[p][ax] = clip32(negate ? vel[p][ax] - d : vel[p][ax] + d);
      end
    endfunction

    function void note(word_t t);
      result_t e;
      longint n[3];
      longint sc, ii, rel, d, rem, sum, q, nw;
      int a, b;
      a = t.ia;
      b = t.ib;
      n[0] = t.vx;
      n[1] = t.vy;
      n[2] = t.vz;
      sc = t.sc;
      ii = longint'(t.imp);
      e = '{default: 0};
      clipped = 0;
      case (t.act)
        ACT_LOAD_POS: for (int ax = 0; ax < 3; ax++) pos[a][ax] = n[ax];
        ACT_LOAD_VEL: begin
          for (int ax = 0; ax < 3; ax++) vel[a][ax] = n[ax];
          if (sc < 0) begin
            clipped = 1;
            imass[a] = 0;
          end else begin
            imass[a] = sc;
          end
        end
        ACT_CONTACT: begin
          rel = 0;
          for (int ax = 0; ax < 3; ax++) begin
            d = clip32(vel[b][ax] - vel[a][ax]);
            rel += (d * n[ax]) >>> 14;
          end
          rem = clip32(rel - ((sc * recip) >>> 16));
          sum = imass[a] + imass[b];
          if (sum == 0) begin
            e.degen = 1;
            e.imp = ii[30:0];
          end else begin
            q = (rem * 65536) / sum;
            nw = q + ii;
            if (nw < 0) nw = 0;
            if (nw > 64'sd2147483647) begin
              nw = 64'sd2147483647;
              clipped = 1;
            end
            e.imp = nw[30:0];
            push_impulse(a, nw - ii, n, 0);
            push_impulse(b, nw - ii, n, 1);
          end
        end
        ACT_INTEG: begin
          for (int ax = 0; ax < 3; ax++)
            pos[a][ax] = clip32(pos[a][ax] + ((vel[a][ax] * dt) >>> 16));
          if (imass[a] != 0) vel[a][1] = clip32(vel[a][1] + ((grav * dt) >>> 16));
        end
        ACT_READ_POS: begin
          e.x = pos[a][0];
          e.y = pos[a][1];
          e.z = pos[a][2];
        end
        ACT_READ_VEL: begin
          e.x = vel[a][0];
          e.y = vel[a][1];
          e.z = vel[a][2];
          e.im = imass[a][30:0];
        end
        default: ;
      endcase
      e.sat = clipped;
      due = {due, e};
    endfunction

    function void cmp(string f, longint e, longint g);
      if (e != g) begin
        $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, f, e, g);
        errors++;
      end
    endfunction

    function void check(result_t g);
      result_t e;
      if (due.size() == 0) begin
        $display("%0t: output word with none expected, actual impulse %0d", $time, g.imp);
        errors++;
        return;
      end
      e = due.pop_front();
      cmp("impulse_out", e.imp, g.imp);
      cmp("res_x", e.x, g.x);
      cmp("res_y", e.y, g.y);
      cmp("res_z", e.z, g.z);
      cmp("res_inv_mass", e.im, g.im);
      cmp("degenerate", e.degen, g.degen);
      cmp("saturated", e.sat, g.sat);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_index = CFG_TIME_STEP;
  logic [31:0] cfg_wdata = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [2:0] in_action = ACT_LOAD_POS;
  logic [9:0] in_index_a = 0;
  logic [9:0] in_index_b = 0;
  logic signed [31:0] in_vec_x = 0;
  logic signed [31:0] in_vec_y = 0;
  logic signed [31:0] in_vec_z = 0;
  logic signed [31:0] in_scalar_in = 0;
  logic [30:0] in_impulse_in = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [30:0] out_impulse_out;
  logic signed [31:0] out_res_x;
  logic signed [31:0] out_res_y;
  logic signed [31:0] out_res_z;
  logic [30:0] out_res_inv_mass;
  logic out_degenerate;
  logic out_saturated;

  particle_contact_impulse_solver_core dut (.*);

  solver_scoreboard sb = new();
  int cycle = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit loaded[1024];
  int pool[$];

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    word_t w;
    result_t r;
    cycle <= cycle + 1;
    if (rst_n && in_valid && !in_stall) begin
      w = '{in_action, in_index_a, in_index_b, in_vec_x, in_vec_y, in_vec_z,
            in_scalar_in, in_impulse_in};
      sb.note(w);
    end
    if (rst_n && out_valid && !out_stall) begin
      r = '{out_impulse_out, out_res_x, out_res_y, out_res_z, out_res_inv_mass,
            out_degenerate, out_saturated};
      sb.check(r);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (cycle % 1000 < 200 || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 0;
      stall_left <= 0;
    end
  end

  function automatic logic [31:0] any_val();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 0;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 1 << 20) - (1 << 19);
    endcase
  endfunction

  function automatic logic [31:0] normal_val();
    if ($urandom_range(0, 9) == 0) return any_val();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  function automatic logic [31:0] mass_val();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return -$urandom_range(1, 1000);
      2: return any_val();
      default: return $urandom_range(1, 1 << 18);
    endcase
  endfunction

  function automatic logic [30:0] impulse_val();
    case ($urandom_range(0, 7))
      0: return 31'h7fffffff;
      1: return 0;
      2: return $urandom;
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  task automatic send(word_t w);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      in_valid = 0;
      repeat (g - 1) @(negedge clk);
      @(negedge clk);
    end
    in_valid = 1;
    in_action = w.act;
    in_index_a = w.ia;
    in_index_b = w.ib;
    in_vec_x = w.vx;
    in_vec_y = w.vy;
    in_vec_z = w.vz;
    in_scalar_in = w.sc;
    in_impulse_in = w.imp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_op(logic [2:0] act, int a, int b, logic [31:0] x, logic [31:0] y,
                         logic [31:0] z, logic [31:0] s, logic [30:0] imp);
    word_t w;
    w = '{act, a[9:0], b[9:0], x, y, z, s, imp};
    send(w);
  endtask

  task automatic load_particle(int p);
    send_op(ACT_LOAD_POS, p, $urandom, any_val(), any_val(), any_val(), $urandom, $urandom);
    send_op(ACT_LOAD_VEL, p, $urandom, any_val(), any_val(), any_val(), mass_val(),
            $urandom);
    if (!loaded[p]) pool = {pool, p};
    loaded[p] = 1;
  endtask

  task automatic drain_and_write(logic [31:0] dtv, logic [31:0] rcv, logic [31:0] gv);
    @(negedge clk);
    in_valid = 0;
    wait (sb.due.size() == 0);
    repeat (20) @(negedge clk);
    cfg_we = 1;
    cfg_index = CFG_TIME_STEP;
    cfg_wdata = dtv;
    sb.set_reg(CFG_TIME_STEP, dtv);
    @(negedge clk);
    cfg_index = CFG_STEP_RECIP;
    cfg_wdata = rcv;
    sb.set_reg(CFG_STEP_RECIP, rcv);
    @(negedge clk);
    cfg_index = CFG_GRAVITY_Y;
    cfg_wdata = gv;
    sb.set_reg(CFG_GRAVITY_Y, gv);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_item();
    int r, a, b;
    r = $urandom_range(0, 99);
    a = pool[$urandom_range(0, pool.size() - 1)];
    b = pool[$urandom_range(0, pool.size() - 1)];
    if (r < 40)
      send_op(ACT_CONTACT, a, b, normal_val(), normal_val(), normal_val(),
              ($urandom_range(0, 3) == 0) ? any_val() : $urandom_range(0, 8192) - 4096,
              impulse_val());
    else if (r < 58)
      send_op(ACT_INTEG, a, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    else if (r < 66)
      send_op(ACT_READ_POS, a, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
    else if (r < 76)
      send_op(ACT_READ_VEL, a, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom);
    else if (r < 84)
      send_op(ACT_LOAD_POS, a, $urandom, any_val(), any_val(), any_val(), $urandom,
              $urandom);
    else if (r < 92)
      send_op(ACT_LOAD_VEL, a, $urandom, any_val(), any_val(), any_val(), mass_val(),
              $urandom);
    else if (r < 96)
      load_particle($urandom_range(0, 1023));
    else
      send_op(r[0] ? ACT_SPARE_LO : ACT_SPARE_HI, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: corner indices, zero and negative masses, clipping and spare codes.
    send_op(ACT_LOAD_POS, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0);
    send_op(ACT_LOAD_VEL, 0, 0, 32'h7fffffff, 32'h80000000, 65536, 65536, 0);
    send_op(ACT_LOAD_POS, 1023, 1023, 100, -100, 0, 0, 0);
    send_op(ACT_LOAD_VEL, 1023, 1023, 32'h80000000, 32'h7fffffff, -65536, 32'h7fffffff,
            31'h7fffffff);
    send_op(ACT_LOAD_POS, 5, 0, 0, 0, 0, 0, 0);
    send_op(ACT_LOAD_VEL, 5, 0, 0, 0, 0, 0, 0);
    send_op(ACT_LOAD_POS, 6, 0, 1, 2, 3, 0, 0);
    send_op(ACT_LOAD_VEL, 6, 0, 4096, -4096, 0, -5, 0);
    foreach (pool[i]) ;
    pool = '{0, 1023, 5, 6};
    loaded[0] = 1;
    loaded[1023] = 1;
    loaded[5] = 1;
    loaded[6] = 1;
    send_op(ACT_CONTACT, 0, 1023, 16384, 0, 0, 32'hffff0000, 0);
    send_op(ACT_CONTACT, 5, 6, 0, 16384, 0, 0, 1000);
    send_op(ACT_CONTACT, 0, 0, 32'h7fffffff, 32'h80000000, 16384, 32'h7fffffff,
            31'h7fffffff);
    send_op(ACT_CONTACT, 1023, 0, -16384, 16384, 32'h80000000, 32'h80000000, 0);
    send_op(ACT_INTEG, 0, 1023, 0, 0, 0, 0, 0);
    send_op(ACT_INTEG, 5, 0, 0, 0, 0, 0, 0);
    send_op(ACT_INTEG, 1023, 0, 0, 0, 0, 0, 0);
    send_op(ACT_READ_POS, 0, 0, 0, 0, 0, 0, 0);
    send_op(ACT_READ_VEL, 1023, 0, 0, 0, 0, 0, 0);
    send_op(ACT_READ_VEL, 6, 0, 0, 0, 0, 0, 0);
    send_op(ACT_SPARE_LO, 1023, 1023, -1, -1, -1, -1, 31'h7fffffff);
    send_op(ACT_SPARE_HI, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) load_particle($urandom_range(0, 1023));

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: drain_and_write(32'h7fffffff, 0, 32'h80000000);
        2: drain_and_write(0, 32'h7fffffff, 32'h7fffffff);
        3: drain_and_write($urandom, $urandom, $urandom);
        4: drain_and_write(TIME_STEP_RST, STEP_RECIP_RST, $urandom_range(0, 1 << 21) -
                           (1 << 20));
        default: ;
      endcase
      for (int i = 0; i < 330; i++) random_item();
    end

    @(negedge clk);
    in_valid = 0;
    wait (sb.due.size() == 0);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
